FILE: src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg
// shared widths, cofactor lane map and status codes for the 3x3 inverse core
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DW        = 32;            // element width, q16.16
    localparam int LANES     = 9;
    localparam int CW        = 2 * DW + 1;    // cofactor width, q32.32 signed
    localparam int DMW       = 96;            // determinant magnitude, q48.48
    localparam int DSW       = DMW + 3;       // signed determinant sum width
    localparam int DETW      = 64;            // determinant field, q32.32
    localparam int DIV_STEPS = DW;            // quotient bits per lane
    localparam int LAT       = DIV_STEPS + 8; // stages from accept to lane result
    localparam int IN_W      = LANES * DW;
    localparam int OUT_W     = LANES * DW + DETW;

    // element indexes p, q, r, s of each adjugate lane: m[p]*m[q] - m[r]*m[s]
    localparam int COF_IDX [LANES][4] = '{
        '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
        '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
        '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
    };

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SINGULAR  = 2'd1,
        ST_SATURATED = 2'd2
    } status_t;

endpackage

FILE: src/mi3_lane.sv
// ----------------------------------------------------------------------------
// mi3_lane
// one adjugate element: cofactor, magnitude and a pipelined restoring divider
// ----------------------------------------------------------------------------
module mi3_lane import mi3_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [DW-1:0]  xa,
    input  logic signed [DW-1:0]  xb,
    input  logic signed [DW-1:0]  xc,
    input  logic signed [DW-1:0]  xd,
    input  logic [DMW-1:0]        det_mag,
    input  logic                  det_neg,
    input  logic [DMW-1:0]        den [DIV_STEPS],
    output logic signed [CW-1:0]  cof,
    output logic signed [DW-1:0]  b,
    output logic                  sat
);

    localparam logic [DW-1:0] LIM_POS = {1'b0, {(DW-1){1'b1}}};
    localparam logic [DW-1:0] LIM_NEG = {1'b1, {(DW-1){1'b0}}};

    logic signed [2*DW-1:0] p_reg;
    logic signed [2*DW-1:0] q_reg;
    logic signed [CW-1:0]   cof_reg;
    logic [2*DW-1:0]        am_reg [4];
    logic                   an_reg [4];
    logic [DMW-1:0]         rem_reg [DIV_STEPS+1];
    logic [DW-1:0]          quo_reg [DIV_STEPS+1];
    logic                   neg_reg [DIV_STEPS+1];
    logic                   ovf_reg [DIV_STEPS+1];
    logic signed [DW-1:0]   b_reg;
    logic                   sat_reg;

    logic [DMW-1:0]         rem_next [DIV_STEPS+1];
    logic                   qbit     [DIV_STEPS+1];
    logic signed [CW-1:0]   cof_abs;
    logic [DW-1:0]          lim;
    logic                   sat_next;
    logic [DW-1:0]          mag_next;

    assign cof_abs = cof_reg[CW-1] ? -cof_reg : cof_reg;

    assign rem_next[0] = '0;
    assign qbit[0]     = 1'b0;

    for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
        logic [DMW:0] rem2;
        logic [DMW:0] diff;
        always_comb
        begin
            rem2        = {rem_reg[k-1], 1'b0};
            diff        = rem2 - {1'b0, den[k-1]};
            qbit[k]     = (rem2 >= {1'b0, den[k-1]});
            rem_next[k] = qbit[k] ? diff[DMW-1:0] : rem2[DMW-1:0];
        end
    end

    always_comb
    begin
        lim      = neg_reg[DIV_STEPS] ? LIM_NEG : LIM_POS;
        sat_next = ovf_reg[DIV_STEPS] || (quo_reg[DIV_STEPS] > lim);
        mag_next = sat_next ? lim : quo_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg     <= (2*DW)'(xa) * (2*DW)'(xb);
            q_reg     <= (2*DW)'(xc) * (2*DW)'(xd);
            cof_reg   <= CW'(p_reg) - CW'(q_reg);
            am_reg[0] <= cof_abs[2*DW-1:0];
            an_reg[0] <= cof_reg[CW-1];
            am_reg[1] <= am_reg[0];
            an_reg[1] <= an_reg[0];
            am_reg[2] <= am_reg[1];
            an_reg[2] <= an_reg[1];
            am_reg[3] <= am_reg[2];
            an_reg[3] <= an_reg[2];
            // quotient bits above the q16.16 range are all zero unless adj >= det
            ovf_reg[0] <= ({{(DMW-2*DW){1'b0}}, am_reg[3]} >= det_mag);
            rem_reg[0] <= {{(DMW-2*DW){1'b0}}, am_reg[3]};
            quo_reg[0] <= '0;
            neg_reg[0] <= an_reg[3] ^ det_neg;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                rem_reg[k] <= rem_next[k];
                quo_reg[k] <= {quo_reg[k-1][DW-2:0], qbit[k]};
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
            b_reg   <= neg_reg[DIV_STEPS] ? -$signed(mag_next) : $signed(mag_next);
            sat_reg <= sat_next;
        end
    end

    assign cof = cof_reg;
    assign b   = b_reg;
    assign sat = sat_reg;

endmodule

FILE: src/mi3_det.sv
// ----------------------------------------------------------------------------
// mi3_det
// determinant by expansion along row 0, magnitude and saturated q32.32 field
// ----------------------------------------------------------------------------
module mi3_det import mi3_pkg::*;
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [DW-1:0] m [3],
    input  logic signed [CW-1:0] c [3],
    output logic [DMW-1:0]       det_mag,
    output logic                 det_neg,
    output logic                 det_zero,
    output logic [DETW-1:0]      det_val,
    output logic                 det_sat
);

    localparam int LOW_W = CW - DW;   // low cofactor slice, taken unsigned
    localparam int PLW   = DW + LOW_W + 1;
    localparam int PHW   = 2 * DW;
    localparam int DFW   = DMW - 16;

    logic signed [PHW-1:0] ph_reg [3];
    logic signed [PLW-1:0] pl_reg [3];
    logic signed [DSW-1:0] t_reg [3];
    logic signed [DSW-1:0] sum_reg;
    logic [DMW-1:0]        mag_reg;
    logic                  neg_reg;
    logic                  zero_reg;
    logic [DETW-1:0]       val_reg;
    logic                  sat_reg;

    logic signed [DSW-1:0] sum_abs;
    logic [DFW-1:0]        dm;
    logic                  sat_next;
    logic [DETW-1:0]       m64;

    assign sum_abs = sum_reg[DSW-1] ? -sum_reg : sum_reg;

    always_comb
    begin
        dm = mag_reg[DMW-1:16];
        if (neg_reg)
            sat_next = (dm[DFW-1:DETW] != '0) || (dm[DETW-1] && (dm[DETW-2:0] != '0));
        else
            sat_next = (dm[DFW-1:DETW-1] != '0);
        if (sat_next)
            m64 = neg_reg ? {1'b1, {(DETW-1){1'b0}}} : {1'b0, {(DETW-1){1'b1}}};
        else
            m64 = dm[DETW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ph_reg[i] <= PHW'(m[i]) * PHW'($signed(c[i][CW-1:LOW_W]));
                pl_reg[i] <= PLW'(m[i]) * PLW'($signed({1'b0, c[i][LOW_W-1:0]}));
                t_reg[i]  <= (DSW'(ph_reg[i]) <<< LOW_W) + DSW'(pl_reg[i]);
            end
            sum_reg  <= t_reg[0] + t_reg[1] + t_reg[2];
            neg_reg  <= sum_reg[DSW-1];
            mag_reg  <= sum_abs[DMW-1:0];
            zero_reg <= (sum_reg == '0);
            sat_reg  <= sat_next;
            val_reg  <= neg_reg ? (~m64 + 1'b1) : m64;
        end
    end

    assign det_mag  = mag_reg;
    assign det_neg  = neg_reg;
    assign det_zero = zero_reg;
    assign det_val  = val_reg;
    assign det_sat  = sat_reg;

endmodule

FILE: src/matrix_inverse_3x3_core.sv
// throughput: one transaction per cycle while the skid register is empty;
// every divider step in each lane is its own stage
// a skid register at the output keeps s_tready registered and lets one result wait
// reset clears all valid flags, but not the data in the output and skid registers
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_core
// 3x3 q16.16 inverse by the adjugate, nine divider lanes and a merging stage
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_core import mi3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // a00 a01 a02 a10 a11 a12 a20 a21 a22
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // b00 b01 b02 b10 b11 b12 b20 b21 b22 determinant
    output logic [1:0]        m_tuser    // status
);

    logic signed [DW-1:0] m_in [LANES];
    logic signed [CW-1:0] cof_w [LANES];
    logic signed [DW-1:0] b_w [LANES];
    logic                 sat_w [LANES];
    logic signed [DW-1:0] row1_reg [3];
    logic signed [DW-1:0] row2_reg [3];
    logic signed [CW-1:0] cdet [3];
    logic [DMW-1:0]       det_mag;
    logic                 det_neg;
    logic                 det_zero;
    logic [DETW-1:0]      det_val;
    logic                 det_sat;
    logic [DMW-1:0]       den_reg [DIV_STEPS];
    logic                 zd_reg [7:LAT];
    logic [DETW-1:0]      dv_reg [8:LAT];
    logic                 ds_reg [8:LAT];
    logic                 vld_reg [1:LAT];

    logic                 en;
    logic                 any_sat;
    logic [OUT_W-1:0]     mrg_data;
    logic [1:0]           mrg_user;

    logic [OUT_W-1:0]     out_data_reg, out_data_next;
    logic [1:0]           out_user_reg, out_user_next;
    logic                 out_vld_reg,  out_vld_next;
    logic [OUT_W-1:0]     skid_data_reg, skid_data_next;
    logic [1:0]           skid_user_reg, skid_user_next;
    logic                 skid_vld_reg,  skid_vld_next;

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    for (genvar i = 0; i < LANES; i++) begin : g_in
        assign m_in[i] = $signed(s_tdata[i*DW +: DW]);
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mi3_lane u_lane (
            .clk     (clk),
            .en      (en),
            .xa      (m_in[COF_IDX[g][0]]),
            .xb      (m_in[COF_IDX[g][1]]),
            .xc      (m_in[COF_IDX[g][2]]),
            .xd      (m_in[COF_IDX[g][3]]),
            .det_mag (det_mag),
            .det_neg (det_neg),
            .den     (den_reg),
            .cof     (cof_w[g]),
            .b       (b_w[g]),
            .sat     (sat_w[g])
        );
    end

    assign cdet[0] = cof_w[0];
    assign cdet[1] = cof_w[3];
    assign cdet[2] = cof_w[6];

    mi3_det u_det (
        .clk      (clk),
        .en       (en),
        .m        (row2_reg),
        .c        (cdet),
        .det_mag  (det_mag),
        .det_neg  (det_neg),
        .det_zero (det_zero),
        .det_val  (det_val),
        .det_sat  (det_sat)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                row1_reg[i] <= m_in[i];
                row2_reg[i] <= row1_reg[i];
            end
            den_reg[0] <= det_mag;
            for (int k = 1; k < DIV_STEPS; k++)
                den_reg[k] <= den_reg[k-1];
            zd_reg[7] <= det_zero;
            for (int k = 8; k <= LAT; k++)
                zd_reg[k] <= zd_reg[k-1];
            dv_reg[8] <= det_val;
            ds_reg[8] <= det_sat;
            for (int k = 9; k <= LAT; k++)
            begin
                dv_reg[k] <= dv_reg[k-1];
                ds_reg[k] <= ds_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= s_tvalid;
            for (int k = 2; k <= LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // merge lane results with the determinant, or all zero fields for a singular matrix
    always_comb
    begin
        any_sat = ds_reg[LAT];
        for (int i = 0; i < LANES; i++)
            any_sat = any_sat | sat_w[i];
        if (zd_reg[LAT])
        begin
            mrg_data = '0;
            mrg_user = ST_SINGULAR;
        end
        else
        begin
            for (int i = 0; i < LANES; i++)
                mrg_data[i*DW +: DW] = b_w[i];
            mrg_data[LANES*DW +: DETW] = dv_reg[LAT];
            mrg_user = any_sat ? ST_SATURATED : ST_OK;
        end
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        out_vld_next   = out_vld_reg;
        skid_data_next = skid_data_reg;
        skid_user_next = skid_user_reg;
        skid_vld_next  = skid_vld_reg;
        if (en && vld_reg[LAT])
        begin
            if (out_vld_reg && !m_tready)
            begin
                skid_data_next = mrg_data;
                skid_user_next = mrg_user;
                skid_vld_next  = 1'b1;
            end
            else
            begin
                out_data_next = mrg_data;
                out_user_next = mrg_user;
                out_vld_next  = 1'b1;
            end
        end
        else if (m_tready)
        begin
            if (skid_vld_reg)
            begin
                out_data_next = skid_data_reg;
                out_user_next = skid_user_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

FILE: src/mi3_checker.sv
// ----------------------------------------------------------------------------
// mi3_checker
// port-level checks for the 3x3 inverse core
// ----------------------------------------------------------------------------
module mi3_checker import mi3_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic [1:0]       m_tuser
);

    // output transaction held until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped before transaction");

    // singular result carries all zero fields
    a_singular: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == ST_SINGULAR) |-> (m_tdata == '0))
        else $error("singular result with nonzero fields");

    // input stalls only after an output stall
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> $past(m_tvalid && !m_tready))
        else $error("s_tready low without output backpressure");

    // status never takes the unused code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_SINGULAR || m_tuser == ST_SATURATED))
        else $error("unused status code");

endmodule

bind matrix_inverse_3x3_core mi3_checker u_mi3_checker (.*);

FILE: dv/tb_matrix_inverse_3x3_core.sv
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3_core
// streams 3x3 q16.16 matrices through the inverse core and compares each
// result with an exact software predictor: directed corner matrices first,
// then random ones, with random gaps on both sides and one long output stall
// ----------------------------------------------------------------------------
module tb_matrix_inverse_3x3_core;
    import mi3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IN_W-1:0]  data;
        logic             known;
        logic [OUT_W-1:0] res;
        status_t          st;
    } row_t;

    typedef struct {
        logic [OUT_W-1:0] res;
        status_t          st;
    } inverse_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic [1:0]        m_tuser;

    inverse_t pending_q[$];
    row_t     directed[$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       stim_done = 1'b0;
    bit       hold_off = 1'b0;

    matrix_inverse_3x3_core uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic inverse_t predict_inverse(logic [IN_W-1:0] mat);
        logic signed [DW-1:0]  e [LANES];
        logic signed [127:0]   adj [LANES];
        logic signed [127:0]   det;
        logic [127:0]          mag, num, qmag;
        logic signed [127:0]   quo;
        logic signed [127:0]   dq;
        bit                    sat;
        inverse_t              r;
        sat = 1'b0;
        r.res = '0;
        for (int i = 0; i < LANES; i++)
            e[i] = mat[i*DW +: DW];
        for (int i = 0; i < LANES; i++)
            adj[i] = 128'(e[COF_IDX[i][0]]) * 128'(e[COF_IDX[i][1]])
                   - 128'(e[COF_IDX[i][2]]) * 128'(e[COF_IDX[i][3]]);
        det = 128'(e[0]) * adj[0] + 128'(e[1]) * adj[3] + 128'(e[2]) * adj[6];
        if (det == 0)
        begin
            r.st = ST_SINGULAR;
            return r;
        end
        mag = det < 0 ? -det : det;
        for (int i = 0; i < LANES; i++)
        begin
            num = (adj[i] < 0 ? -adj[i] : adj[i]) << 32;
            qmag = num / mag;
            quo = ((adj[i] < 0) != (det < 0)) ? -$signed(qmag) : $signed(qmag);
            if (quo > 128'sh7FFFFFFF)
            begin
                quo = 128'sh7FFFFFFF;
                sat = 1'b1;
            end
            else if (quo < -128'sh80000000)
            begin
                quo = -128'sh80000000;
                sat = 1'b1;
            end
            r.res[i*DW +: DW] = quo[DW-1:0];
        end
        qmag = mag >> 16;
        dq = det < 0 ? -$signed(qmag) : $signed(qmag);
        if (dq > 128'sh7FFFFFFFFFFFFFFF)
        begin
            dq = 128'sh7FFFFFFFFFFFFFFF;
            sat = 1'b1;
        end
        else if (dq < -128'sh8000000000000000)
        begin
            dq = -128'sh8000000000000000;
            sat = 1'b1;
        end
        r.res[LANES*DW +: DETW] = dq[DETW-1:0];
        r.st = sat ? ST_SATURATED : ST_OK;
        return r;
    endfunction

    function automatic logic [IN_W-1:0] pack_matrix(int unsigned v [LANES]);
        logic [IN_W-1:0] d;
        for (int i = 0; i < LANES; i++)
            d[i*DW +: DW] = v[i];
        return d;
    endfunction

    function automatic logic [DW-1:0] rand_element();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 4) << 16;
            2: return -($urandom_range(0, 4) << 16);
            3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            4: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
            default: return 32'($signed(32'($urandom_range(0, 65535)))
                                - 32'sd32768) << $urandom_range(0, 12);
        endcase
    endfunction

    task automatic add_row(int unsigned v [LANES]);
        row_t r;
        r.data = pack_matrix(v);
        r.known = 1'b0;
        r.res = '0;
        r.st = ST_OK;
        directed.push_back(r);
    endtask

    task automatic add_known(int unsigned v [LANES], logic [OUT_W-1:0] res, status_t st);
        row_t r;
        r.data = pack_matrix(v);
        r.known = 1'b1;
        r.res = res;
        r.st = st;
        directed.push_back(r);
    endtask

    task automatic send_matrix(logic [IN_W-1:0] d);
        inverse_t exp_r;
        int gap;
        gap = $urandom_range(0, 16) * $urandom_range(0, 1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        exp_r = predict_inverse(d);
        pending_q.push_back(exp_r);
        @(negedge clk);
    endtask

    task automatic send_known(row_t r);
        inverse_t chk;
        chk = predict_inverse(r.data);
        if (r.known && (chk.res !== r.res || chk.st !== r.st))
        begin
            $display("%0t table row disagrees: expected %h/%0d, predictor %h/%0d",
                     $time, r.res, r.st, chk.res, chk.st);
            errors++;
        end
        send_matrix(r.data);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_q.size() == 0)
            begin
                $display("%0t unexpected transaction: actual %h/%0d", $time, m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                inverse_t exp_r;
                exp_r = pending_q.pop_front();
                for (int i = 0; i < LANES; i++)
                    if (m_tdata[i*DW +: DW] !== exp_r.res[i*DW +: DW])
                    begin
                        $display("%0t b%0d%0d mismatch: expected %h actual %h", $time,
                                 i / 3, i % 3, exp_r.res[i*DW +: DW], m_tdata[i*DW +: DW]);
                        errors++;
                    end
                if (m_tdata[LANES*DW +: DETW] !== exp_r.res[LANES*DW +: DETW])
                begin
                    $display("%0t determinant mismatch: expected %h actual %h", $time,
                             exp_r.res[LANES*DW +: DETW], m_tdata[LANES*DW +: DETW]);
                    errors++;
                end
                if (m_tuser !== exp_r.st)
                begin
                    $display("%0t status mismatch: expected %0d actual %0d", $time,
                             exp_r.st, m_tuser);
                    errors++;
                end
            end
        end
    end

    // output side: random stalls, with one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            gap = $urandom_range(0, 1) ? $urandom_range(0, 16) : 0;
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int unsigned z [LANES];
        int unsigned v [LANES];
        logic [OUT_W-1:0] res;
        logic [IN_W-1:0] d;
        int kind;
        z = '{default: 0};
        // zero matrix is singular
        add_known(z, '0, ST_SINGULAR);
        // identity
        v = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000};
        res = '0;
        res[0 +: DW] = 32'h10000;
        res[4*DW +: DW] = 32'h10000;
        res[8*DW +: DW] = 32'h10000;
        res[LANES*DW +: DETW] = 64'h1_0000_0000;
        add_known(v, res, ST_OK);
        // rank one, all max or all min
        v = '{default: 32'h7FFFFFFF};
        add_known(v, '0, ST_SINGULAR);
        v = '{default: 32'h80000000};
        add_known(v, '0, ST_SINGULAR);
        // tiny determinant: lsb diagonal
        v = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        add_row(v);
        // huge diagonal saturates determinant
        v = '{32'h80000000, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h80000000};
        add_row(v);
        v = '{32'h7FFFFFFF, 0, 0, 0, 32'h80000000, 0, 0, 0, 32'h7FFFFFFF};
        add_row(v);
        v = '{32'hFFFF0000, 0, 0, 0, 32'h20000, 0, 0, 0, 32'h8000};
        add_row(v);
        v = '{0, 32'h10000, 0, 0, 0, 32'h10000, 32'h10000, 0, 0};
        add_row(v);
        v = '{32'h10000, 32'h20000, 32'h30000, 32'h40000, 32'h50000, 32'h60000,
              32'h70000, 32'h80000, 32'hA0000};
        add_row(v);
        v = '{32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
              32'h12345678, 32'hFEDCBA98, 32'h0F0F0F0F, 32'hF0F0F0F0};
        add_row(v);
        v = '{2, 1, 0, 1, 2, 1, 0, 1, 2};
        add_row(v);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send_known(directed[i]);
        for (int n = 0; n < 900; n++)
        begin
            if (n == 450)
                hold_off = 1'b1;
            kind = $urandom_range(0, 9);
            for (int i = 0; i < LANES; i++)
                d[i*DW +: DW] = rand_element();
            if (kind == 0)
                d[6*DW +: 3*DW] = d[3*DW +: 3*DW];
            else if (kind == 1)
                d[0 +: 3*DW] = '0;
            send_matrix(d);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: matrix_inverse_3x3_core.f
src/mi3_pkg.sv
src/mi3_lane.sv
src/mi3_det.sv
src/matrix_inverse_3x3_core.sv
src/mi3_checker.sv
dv/tb_matrix_inverse_3x3_core.sv
